### hw/rtl/pbs_pkg.sv
package pbs_pkg;

    localparam int PIX_W      = 24;
    localparam int LUMA_W     = 15;
    localparam int KEY_W      = LUMA_W + PIX_W;
    localparam int DEPTH_DFLT = 64;

    typedef struct packed {
        logic              valid;
        logic [LUMA_W-1:0] luma;
        logic [PIX_W-1:0]  pixel;
    } pbs_ent_t;

    typedef struct packed {
        logic insert;
        logic shift;
    } pbs_ctrl_t;

    function automatic logic [LUMA_W-1:0] luma_of(input logic [PIX_W-1:0] pix);
        logic [LUMA_W-1:0] r_term;
        logic [LUMA_W-1:0] g_term;
        logic [LUMA_W-1:0] b_term;
        r_term = LUMA_W'(pix[23:16]) * LUMA_W'(30);
        g_term = LUMA_W'(pix[15:8]) * LUMA_W'(59);
        b_term = LUMA_W'(pix[7:0]) * LUMA_W'(11);
        return r_term + g_term + b_term;
    endfunction

    // bit i: blue -> 3i, green -> 3i+1, red -> 3i+2
    function automatic logic [PIX_W-1:0] weave_bits(input logic [PIX_W-1:0] pix);
        logic [PIX_W-1:0] w;
        w = '0;
        for (int i = 0; i < 8; i++) begin
            w[3*i]     = pix[i];
            w[3*i + 1] = pix[i + 8];
            w[3*i + 2] = pix[i + 16];
        end
        return w;
    endfunction

    function automatic logic [KEY_W-1:0] key_of(input pbs_ent_t e);
        return {e.luma, weave_bits(e.pixel)};
    endfunction

endpackage

### hw/rtl/pbs_key.sv
module pbs_key
    import pbs_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                accept,
    input  logic [PIX_W-1:0]    pixel,
    input  logic                last,
    output logic                stage_valid,
    output logic                stage_last,
    output pbs_ent_t            stage_ent
);

    logic     valid_reg;
    logic     last_reg;
    pbs_ent_t ent_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= accept;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            last_reg      <= last;
            ent_reg.valid <= 1'b1;
            ent_reg.luma  <= luma_of(pixel);
            ent_reg.pixel <= pixel;
        end
    end

    assign stage_valid = valid_reg;
    assign stage_last  = last_reg;
    assign stage_ent   = ent_reg;

endmodule

### hw/rtl/pbs_cell.sv
module pbs_cell
    import pbs_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  pbs_ctrl_t ctrl,
    input  pbs_ent_t  new_ent,
    input  pbs_ent_t  prev_ent,
    input  logic      prev_gt,
    input  pbs_ent_t  next_ent,
    output pbs_ent_t  ent,
    output logic      gt
);

    pbs_ent_t ent_reg;
    pbs_ent_t ent_next;

    // empty cells count as larger than anything
    assign gt = !ent_reg.valid || (key_of(ent_reg) > key_of(new_ent));

    always_comb begin
        ent_next = ent_reg;
        if (ctrl.shift) begin
            ent_next = next_ent;
        end else if (ctrl.insert && gt) begin
            ent_next = prev_gt ? prev_ent : new_ent;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ent_reg.valid <= 1'b0;
        end else begin
            ent_reg.valid <= ent_next.valid;
        end
    end

    always_ff @(posedge aclk) begin
        ent_reg.luma  <= ent_next.luma;
        ent_reg.pixel <= ent_next.pixel;
    end

    assign ent = ent_reg;

endmodule

### hw/rtl/pixel_brightness_sorter_core.sv
// Pixel brightness sorter.
// Input stream: one 24-bit pixel per request (red 23..16, green 15..8,
// blue 7..0), s_tlast marks the final pixel of a set. Pixels are kept in a
// row of SORT_DEPTH compare/shift cells, sorted by 30*R+59*G+11*B with ties
// ordered by the bit-interleaved color, and an insert happens in
// every cell at once.
// Collect: one pixel per cycle; pixels beyond SORT_DEPTH are dropped.
// Output: once the last pixel has passed the key stage and set the drain
// flag, the set streams out from cell 0, one pixel per cycle while m_tready is high;
// m_tlast marks the final pixel and m_tuser is set on all of them if any were dropped.
// The input is held off from the last pixel until the final output goes.
// A stall on m_tready freezes the row, the head stays on m_tdata.
// Reset (aresetn low, synchronous) empties the row and the drop flag.
module pixel_brightness_sorter_core
    import pbs_pkg::*;
#(
    parameter int SORT_DEPTH = DEPTH_DFLT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // pixel[23:0]
    input  logic        s_tlast,   // last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // sorted_pixel[23:0]
    output logic        m_tlast,   // final_res
    output logic        m_tuser    // overflow
);

    localparam int CNT_W = $clog2(SORT_DEPTH + 1);

    logic             s_accept;
    logic             m_accept;
    logic             stage_valid;
    logic             stage_last;
    pbs_ent_t         stage_ent;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             dropped_reg;
    logic             dropped_next;
    logic             drain_reg;
    logic             drain_next;
    logic             full;
    pbs_ctrl_t        ctrl;

    pbs_ent_t         ents [SORT_DEPTH];
    logic             gts  [SORT_DEPTH];

    assign s_tready = !drain_reg && !(stage_valid && stage_last);
    assign s_accept = s_tvalid && s_tready;
    assign m_accept = m_tvalid && m_tready;
    assign full     = (count_reg == CNT_W'(SORT_DEPTH));

    assign ctrl.insert = stage_valid && !full;
    assign ctrl.shift  = m_accept;

    pbs_key u_key (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (s_accept),
        .pixel       (s_tdata),
        .last        (s_tlast),
        .stage_valid (stage_valid),
        .stage_last  (stage_last),
        .stage_ent   (stage_ent)
    );

    for (genvar i = 0; i < SORT_DEPTH; i++) begin : g_cell
        pbs_ent_t prev_e;
        pbs_ent_t next_e;
        logic     prev_g;

        if (i == 0) begin : g_head
            assign prev_e = '0;
            assign prev_g = 1'b0;
        end else begin : g_body
            assign prev_e = ents[i-1];
            assign prev_g = gts[i-1];
        end

        if (i == SORT_DEPTH - 1) begin : g_tail
            assign next_e = '0;
        end else begin : g_link
            assign next_e = ents[i+1];
        end

        pbs_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctrl     (ctrl),
            .new_ent  (stage_ent),
            .prev_ent (prev_e),
            .prev_gt  (prev_g),
            .next_ent (next_e),
            .ent      (ents[i]),
            .gt       (gts[i])
        );
    end

    always_comb begin
        count_next   = count_reg;
        dropped_next = dropped_reg;
        drain_next   = drain_reg;
        if (m_accept && m_tlast) begin
            count_next   = '0;
            dropped_next = 1'b0;
            drain_next   = 1'b0;
        end else if (stage_valid) begin
            if (full) begin
                dropped_next = 1'b1;
            end else begin
                count_next = count_reg + CNT_W'(1);
            end
            if (stage_last) begin
                drain_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            dropped_reg <= 1'b0;
            drain_reg   <= 1'b0;
        end else begin
            count_reg   <= count_next;
            dropped_reg <= dropped_next;
            drain_reg   <= drain_next;
        end
    end

    assign m_tvalid = drain_reg;
    assign m_tdata  = ents[0].pixel;
    assign m_tlast  = !ents[1].valid;
    assign m_tuser  = dropped_reg;

endmodule

### hw/rtl/pbs_checker.sv
module pbs_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [23:0] s_tdata,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic        m_tlast,
    input logic        m_tuser
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled output changed");

    a_no_input_on_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("input taken while draining");

    a_last_starts_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tlast |-> ##2 m_tvalid)
        else $error("drain did not start after last request");

    a_final_ends_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tlast |=> !m_tvalid)
        else $error("output continued after final request");

    a_flag_steady: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && $past(m_tvalid) |-> m_tuser == $past(m_tuser))
        else $error("overflow flag changed within a run");

endmodule

bind pixel_brightness_sorter_core pbs_checker u_pbs_checker (.*);

### test/pbs_sort_checker.sv
`timescale 1ns / 1ps

module pbs_sort_checker #(
    parameter int DEPTH = pbs_pkg::DEPTH_DFLT
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_tvalid,
    input  logic                     s_tready,
    input  logic [pbs_pkg::PIX_W-1:0] s_tdata,
    input  logic                     s_tlast,
    input  logic                     m_tvalid,
    input  logic                     m_tready,
    input  logic [pbs_pkg::PIX_W-1:0] m_tdata,
    input  logic                     m_tlast,
    input  logic                     m_tuser,
    output int                       fail_count,
    output int                       pending
);

    localparam int PW = pbs_pkg::PIX_W;

    typedef struct packed {
        logic [PW-1:0] pixel;
        logic          final_px;
        logic          dropped;
    } sorted_px_t;

    sorted_px_t    sorted_due[$];
    logic [PW-1:0] held_set[$];
    logic          set_dropped;
    int            mismatches;

    assign fail_count = mismatches;
    assign pending    = sorted_due.size();

    // brightness in the upper bits, interleaved color below it
    function automatic logic [38:0] rank_key(input logic [PW-1:0] p);
        logic [14:0]   bright;
        logic [PW-1:0] woven;
        bright = 15'(30 * int'(p[23:16]) + 59 * int'(p[15:8]) + 11 * int'(p[7:0]));
        woven  = '0;
        for (int i = 0; i < 8; i++) begin
            woven[3*i]     = p[i];
            woven[3*i + 1] = p[i + 8];
            woven[3*i + 2] = p[i + 16];
        end
        return {bright, woven};
    endfunction

    task automatic take_pixel(input logic [PW-1:0] p, input logic lst);
        int         pos;
        sorted_px_t res;
        if (held_set.size() < DEPTH) begin
            pos = held_set.size();
            while (pos > 0 && rank_key(held_set[pos-1]) > rank_key(p))
                pos--;
            held_set.insert(pos, p);
        end else begin
            set_dropped = 1'b1;
        end
        if (lst) begin
            foreach (held_set[i]) begin
                res.pixel    = held_set[i];
                res.final_px = (i == held_set.size() - 1);
                res.dropped  = set_dropped;
                sorted_due.push_back(res);
            end
            held_set.delete();
            set_dropped = 1'b0;
        end
    endtask

    task automatic check_result();
        sorted_px_t want;
        if (sorted_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: unexpected result pixel=%06h last=%0b ovf=%0b",
                         $time, m_tdata, m_tlast, m_tuser);
            return;
        end
        want = sorted_due.pop_front();
        if (m_tdata !== want.pixel || m_tlast !== want.final_px
                || m_tuser !== want.dropped) begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: mismatch exp pixel=%06h last=%0b ovf=%0b got %06h %0b %0b",
                         $time, want.pixel, want.final_px, want.dropped,
                         m_tdata, m_tlast, m_tuser);
        end
    endtask

    initial begin
        mismatches  = 0;
        set_dropped = 1'b0;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            held_set.delete();
            set_dropped = 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                take_pixel(s_tdata, s_tlast);
            if (m_tvalid && m_tready)
                check_result();
        end
    end

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int PW         = pbs_pkg::PIX_W;
    localparam int IDLE_LIMIT = 5000;

    logic          aclk     = 1'b0;
    logic          aresetn  = 1'b0;
    logic          s_tvalid = 1'b0;
    logic          s_tready;
    logic [PW-1:0] s_tdata  = '0;
    logic          s_tlast  = 1'b0;
    logic          m_tvalid;
    logic          m_tready = 1'b0;
    logic [PW-1:0] m_tdata;
    logic          m_tlast;
    logic          m_tuser;

    int fail_count;
    int pending;
    int idle_pct  = 0;
    int stall_pct = 0;
    int quiet_cycles = 0;

    always #5 aclk = ~aclk;

    pixel_brightness_sorter_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    pbs_sort_checker chk (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("pixel_brightness_sorter_core test failed");
            $finish;
        end
    end

    task automatic send_pixel(input logic [PW-1:0] pix, input logic lst);
        while ($urandom_range(0, 99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pix;
        s_tlast  <= lst;
        do @(posedge aclk); while (!s_tready);
    endtask

    // equal-brightness pairs: 0x3B0000/0x001E00 and 0x0B0000/0x00001E
    function automatic logic [PW-1:0] pick_pixel(input logic [PW-1:0] prev);
        logic [PW-1:0] tie_pool [4];
        tie_pool = '{24'h3B0000, 24'h001E00, 24'h0B0000, 24'h00001E};
        case ($urandom_range(0, 9))
            0: return prev;
            1: return tie_pool[$urandom_range(0, 3)];
            2: return {{8{$urandom_range(0, 1) == 1}}, {8{$urandom_range(0, 1) == 1}},
                       {8{$urandom_range(0, 1) == 1}}};
            default: return PW'($urandom);
        endcase
    endfunction

    task automatic send_set(input int n);
        logic [PW-1:0] pix;
        pix = '0;
        for (int i = 0; i < n; i++) begin
            pix = pick_pixel(pix);
            send_pixel(pix, i == n - 1);
        end
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0)
            @(posedge aclk);
    endtask

    logic [PW-1:0] mixed_set [12];
    int            sent;
    int            n;

    initial begin
        mixed_set = '{24'hFFFFFF, 24'h000000, 24'hFF0000, 24'h00FF00, 24'h0000FF,
                      24'h3B0000, 24'h001E00, 24'h3B0000, 24'h0B0000, 24'h00001E,
                      24'h800000, 24'h000080};
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: extremes, brightness ties, duplicates, single-pixel sets
        foreach (mixed_set[i])
            send_pixel(mixed_set[i], i == 11);
        send_pixel(24'h123456, 1'b1);
        send_pixel(24'hFFFFFF, 1'b1);
        send_pixel(24'h000000, 1'b1);
        send_pixel(24'h7F7F7F, 1'b0);
        send_pixel(24'h7F7F7F, 1'b1);
        wait_drained();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 76; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 76; end
                default: begin idle_pct = 33; stall_pct = 33; end
            endcase
            sent = 0;
            // fills the store, then its tail and last pixel are dropped
            if (phase == 3) begin
                send_set(pbs_pkg::DEPTH_DFLT + 2);
            end
            while (sent < 12) begin
                n = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 20)
                                                : $urandom_range(1, 8);
                send_set(n);
                sent += n;
            end
            wait_drained();
        end

        idle_pct  = 0;
        stall_pct = 0;
        repeat (20) @(posedge aclk);
        if (fail_count == 0 && pending == 0)
            $display("pixel_brightness_sorter_core test passed");
        else
            $display("pixel_brightness_sorter_core test failed");
        $finish;
    end

endmodule
